// ===== hw/rtl/rpn_pkg.sv =====
// Package for the RPN stack evaluator: token kinds, controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;

   localparam logic [2:0] KIND_PUSH  = 3'd0;
   localparam logic [2:0] KIND_ADD   = 3'd1;
   localparam logic [2:0] KIND_SUB   = 3'd2;
   localparam logic [2:0] KIND_MUL   = 3'd3;
   localparam logic [2:0] KIND_DIV   = 3'd4;
   localparam logic [2:0] KIND_PRINT = 3'd5;

   localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

   // Datapath operations for the shared arithmetic unit
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;    // capture request payload
      logic       pop_rd;      // read the top entry and pop (right/left operand)
      logic       take_r;      // latch read data as right operand
      logic       take_l;      // latch read data as left operand
      logic       ar_start;    // start arithmetic
      logic [1:0] ar_op;
      logic       push_op;     // push the captured request value
      logic       push_res;    // push the arithmetic result
      logic       rsp_load;    // load the response register
      logic       show;        // response carries right operand as printed
      logic       zdiv;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic       empty;
      logic       full;
      logic       ar_done;
      logic       r_zero;
      logic [2:0] kind;
   } sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rpn_datapath.sv =====
// Datapath of the RPN stack evaluator: operand stack memory, operand
// registers, iterative multiply/divide unit and response register. Uses rpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpn_datapath #(
   parameter int STACK_DEPTH = 128
) (
   input  wire             clock,
   input  wire             reset,
   input  wire rpn_pkg::cmd_type cmd,
   output rpn_pkg::sts_type sts,
   input  wire [2:0]       req_kind,
   input  wire [63:0]      req_value,
   output logic [63:0]     shown_value,
   output logic [4:0]      flags_out,   // valid, under, over, zdiv, sat
   input  wire             rsp_taken,
   output logic            rsp_full
);
   import rpn_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW = $clog2(STACK_DEPTH + 1);

   logic [63:0] mem [STACK_DEPTH];
   logic [63:0] rd_data;
   logic [FW-1:0] fill_ff, fill_in;
   logic [2:0]  kind_ff;
   logic [63:0] val_ff, r_ff, l_ff;
   logic under_ff, under_in, over_ff, over_in, sat_ff, sat_in;

   // Arithmetic unit state
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [1:0]   op_ff;
   logic         neg_ff, ovr_ff;
   logic [63:0]  x_ff, y_ff, res_ff;
   logic [127:0] acc_ff;
   logic [63:0]  rem_ff;
   logic [63:0]  q_ff;

   assign sts.empty   = (fill_ff == '0);
   assign sts.full    = (fill_ff == FW'(STACK_DEPTH));
   assign sts.ar_done = done_ff;
   assign sts.r_zero  = (r_ff == '0);
   assign sts.kind    = kind_ff;

   // Stack memory: pop reads at fill-1, push writes at fill
   always_ff @(posedge clock) begin
      if (cmd.pop_rd && fill_ff != '0)
         rd_data <= mem[AW'(fill_ff - 1'b1)];
      if ((cmd.push_op || cmd.push_res) && fill_ff != FW'(STACK_DEPTH))
         mem[AW'(fill_ff)] <= cmd.push_op ? val_ff : res_ff;
   end

   always_comb begin
      fill_in  = fill_ff;
      under_in = under_ff;
      over_in  = over_ff;
      if (cmd.load_req) begin
         under_in = 1'b0;
         over_in  = 1'b0;
      end
      if (cmd.pop_rd) begin
         if (fill_ff != '0) fill_in = fill_ff - 1'b1;
         else under_in = 1'b1;
      end
      if (cmd.push_op || cmd.push_res) begin
         if (fill_ff != FW'(STACK_DEPTH)) fill_in = fill_ff + 1'b1;
         else over_in = 1'b1;
      end
   end

   // Popped operand is zero when the stack was empty (read data is registered and taken in the cycle after the pop)
   logic pop_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         under_ff <= 1'b0;
         over_ff  <= 1'b0;
         pop_ok_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         under_ff <= under_in;
         over_ff  <= over_in;
         pop_ok_ff <= cmd.pop_rd && (fill_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         val_ff  <= req_value;
      end
      if (cmd.take_r) r_ff <= pop_ok_ff ? rd_data : '0;
      if (cmd.take_l) l_ff <= pop_ok_ff ? rd_data : '0;
   end

   // Shared arithmetic unit: add/sub in one step, multiply by shift-add
   // over 64 steps, divide by restoring division over 96 steps.
   logic [63:0] xm, ym, s_add, s_sub;
   logic [64:0] trial;
   logic [127:0] prod_r;
   logic [63:0]  mag, qr;
   logic         ov, qb;
   assign xm    = l_ff[63] ? (64'd0 - l_ff) : l_ff;
   assign ym    = r_ff[63] ? (64'd0 - r_ff) : r_ff;
   assign s_add = l_ff + r_ff;
   assign s_sub = l_ff - r_ff;
   assign trial = {rem_ff[63:0], (cnt_ff < 7'd64) ? x_ff[63] : 1'b0};
   assign qb    = trial >= {1'b0, y_ff};

   function automatic logic [64:0] clip(input logic [63:0] m, input logic n,
                                        input logic o);
      if (n) begin
         if (o || m > Q_MIN) return {1'b1, Q_MIN};
         return {1'b0, 64'd0 - m};
      end
      if (o || m > Q_MAX) return {1'b1, Q_MAX};
      return {1'b0, m};
   endfunction

   logic [64:0] clipped;
   always_comb begin
      prod_r = acc_ff + 128'h8000_0000;
      mag = '0;
      qr  = q_ff;
      ov  = ovr_ff;
      if (op_ff == OP_MUL) begin
         mag = prod_r[95:32];
         ov  = prod_r[127:96] != '0;
      end else begin
         if (!ovr_ff && rem_ff[63:0] >= y_ff - rem_ff[63:0]) begin
            qr = q_ff + 1'b1;
            if (qr == '0) ov = 1'b1;
         end
         mag = qr;
      end
      clipped = clip(mag, neg_ff, ov);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.load_req) sat_ff <= 1'b0;
         if (cmd.ar_start) begin
            op_ff  <= cmd.ar_op;
            neg_ff <= l_ff[63] ^ r_ff[63];
            x_ff   <= xm;
            y_ff   <= ym;
            acc_ff <= '0;
            rem_ff <= '0;
            q_ff   <= '0;
            ovr_ff <= 1'b0;
            cnt_ff <= '0;
            if (cmd.ar_op == OP_ADD || cmd.ar_op == OP_SUB) begin
               done_ff <= 1'b1;
               if (cmd.ar_op == OP_ADD) begin
                  if (l_ff[63] == r_ff[63] && s_add[63] != l_ff[63]) begin
                     res_ff <= l_ff[63] ? Q_MIN : Q_MAX;
                     sat_ff <= 1'b1;
                  end else res_ff <= s_add;
               end else begin
                  if (l_ff[63] != r_ff[63] && s_sub[63] != l_ff[63]) begin
                     res_ff <= l_ff[63] ? Q_MIN : Q_MAX;
                     sat_ff <= 1'b1;
                  end else res_ff <= s_sub;
               end
            end else busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (op_ff == OP_MUL) begin
               if (cnt_ff == 7'd64) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  res_ff  <= clipped[63:0];
                  sat_ff  <= clipped[64];
               end else begin
                  acc_ff <= {acc_ff[126:0], 1'b0} +
                            (x_ff[63] ? {64'd0, y_ff} : 128'd0);
                  x_ff   <= {x_ff[62:0], 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end else begin
               if (cnt_ff == 7'd96) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  res_ff  <= clipped[63:0];
                  sat_ff  <= clipped[64];
               end else begin
                  // The remainder stays below the divisor, so 64 bits hold it.
                  rem_ff <= qb ? 64'(trial - {1'b0, y_ff}) : trial[63:0];
                  x_ff   <= {x_ff[62:0], 1'b0};
                  if (cnt_ff < 7'd32) begin
                     if (qb) ovr_ff <= 1'b1;
                  end else q_ff <= {q_ff[62:0], qb};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) rsp_full <= 1'b0;
      else if (cmd.rsp_load) rsp_full <= 1'b1;
      else if (rsp_taken) rsp_full <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         shown_value <= cmd.show ? r_ff : '0;
         flags_out   <= {cmd.show, under_ff, over_ff, cmd.zdiv, sat_ff};
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/rpn_ctrl.sv =====
// Controller of the RPN stack evaluator: sequences pops, arithmetic, push
// and response per request. Uses rpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpn_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_fire,
   output logic             req_ready,
   input  wire              rsp_full,
   input  wire rpn_pkg::sts_type sts,
   output rpn_pkg::cmd_type cmd
);
   import rpn_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_POPR  = 4'd2;
   localparam logic [3:0] S_TAKR  = 4'd3;
   localparam logic [3:0] S_TAKL  = 4'd4;
   localparam logic [3:0] S_START = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_PUSH  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam logic [3:0] S_POPL  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       zdiv_ff, zdiv_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      zdiv_in  = zdiv_ff;
      cmd      = '0;
      cmd.load_req = req_fire;
      unique case (state_ff)
         S_IDLE: begin
            zdiv_in = 1'b0;
            if (req_fire) state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.kind == KIND_PUSH) begin
               cmd.push_op = 1'b1;
               state_in = S_RESP;
            end else if (sts.kind > KIND_PRINT) state_in = S_RESP;
            else begin
               cmd.pop_rd = 1'b1;
               state_in = S_TAKR;
            end
         end
         S_TAKR: begin
            cmd.take_r = 1'b1;
            if (sts.kind == KIND_PRINT) state_in = S_RESP;
            else state_in = S_POPR;
         end
         S_POPR: begin
            // right operand now latched; zero divisor skips the left pop
            if (sts.kind == KIND_DIV && sts.r_zero) begin
               zdiv_in = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in = S_POPL;
            end
         end
         S_POPL: begin
            cmd.take_l = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            cmd.ar_start = 1'b1;
            cmd.ar_op = 2'(sts.kind - 3'd1);
            state_in = S_WAIT;
         end
         S_WAIT: if (sts.ar_done) state_in = S_PUSH;
         S_PUSH: begin
            cmd.push_res = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_full) begin
               cmd.rsp_load = 1'b1;
               cmd.show = (sts.kind == KIND_PRINT);
               cmd.zdiv = zdiv_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         zdiv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         zdiv_ff  <= zdiv_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: joins controller and datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_datapath.
//
// Usage: each request on the req_ channel is a token (kind on tuser and
// Q32.32 operand on tdata); each produces exactly one response on the rsp_
// channel with the printed value and status flags. One request is processed
// at a time.
// Sequence after acceptance: push and unknown kinds decode, then respond; print
// pops and takes the operand, then responds; divide by a zero divisor pops and
// takes the divisor, then responds; other arithmetic pops and takes both
// operands, runs the shared iterative arithmetic unit, pushes the result and
// responds. Add and subtract take one step, multiply one shift-add step per
// multiplier bit, divide one restoring step per quotient bit, 96 steps. The
// next request is accepted the cycle after the response is loaded.
// Reset empties the stack and marks the response register empty; stack memory
// contents are not cleared. A stalled receiver holds the response in its
// output register; the next request may be taken meanwhile and finishes up
// to its response step, where it waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 128
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [63:0]  req_tdata,   // [63:0] operand_value
   input  wire [2:0]   req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] shown_value
   output logic [4:0]  rsp_tuser    // shown_valid, underflow, overflow, zero_divide, saturated
);
   import rpn_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    rsp_full;
   logic [4:0] fl;

   rpn_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready), .req_ready(req_tready),
      .rsp_full(rsp_full && !rsp_tready), .sts(sts), .cmd(cmd)
   );

   rpn_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_kind(req_tuser), .req_value(req_tdata),
      .shown_value(rsp_tdata), .flags_out(fl),
      .rsp_taken(rsp_tready), .rsp_full(rsp_full)
   );

   assign rsp_tvalid = rsp_full;
   // flags packed lowest first: shown_valid at bit 0
   assign rsp_tuser  = {fl[0], fl[1], fl[2], fl[3], fl[4]};

endmodule
`default_nettype wire

// ===== hw/rtl/rpn_checker.sv =====
// Port-level checker for the RPN stack evaluator, bound to the top level.
// Depends on nothing beyond the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module rpn_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire [4:0]  rsp_tuser
);
   // A held response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");
   // Only printed responses carry a value
   a_show: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("value without print");
   // A request is never taken in the cycle after another
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");
   // Zero divide never comes with saturation or overflow
   a_zd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> !rsp_tuser[4] && !rsp_tuser[2])
      else $error("conflicting flags");
endmodule

bind rpn_stack_evaluator rpn_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire
